### design/tsg_pkg.sv
// shared widths, reciprocal constants and types for the triangle setup pipeline
package tsg_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned RootW     = 32;
  localparam int unsigned RadicandW = 64;
  localparam int unsigned QuoW      = 17;
  localparam int unsigned DivNumW   = 49;
  localparam int unsigned FracW     = 18;
  localparam int unsigned R2W       = 48;
  localparam int unsigned InTdataW  = 288;
  localparam int unsigned OutTdataW = 272;

  // floor(u/3) = (u * RecipThree) >> 35 for u below 2^35
  localparam logic [33:0] RecipThree   = 34'd11453246123;
  // floor(u/9) = (u * RecipNine) >> 55 for u below 2^51
  localparam logic [51:0] RecipNine    = 52'd4003199668773775;

  localparam logic [FracW-1:0] QOne        = 18'd65536;
  localparam logic [15:0]      MinLenReset = 16'd1;

  typedef logic [QuoW-1:0] quo_t;

endpackage

### design/tsg_isqrt.sv
// pipelined integer square root, one result bit per stage
module tsg_isqrt (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [tsg_pkg::RadicandW-1:0]     rad_i,
  output logic [tsg_pkg::RootW-1:0]         root_o
);

  localparam int unsigned RW = tsg_pkg::RadicandW;
  localparam int unsigned QW = tsg_pkg::RootW;

  logic [RW-1:0] rem_q  [QW];
  logic [QW-1:0] root_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stg
    localparam int unsigned Bit = QW - 1 - j;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] root_in;
    logic [RW+1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (root + 2^b)^2 - root^2
    assign trial = ((RW+2)'(root_in) << (Bit + 1)) + ((RW+2)'(1) << (2 * Bit));

    // try this bit of the root
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({2'b00, rem_in} >= trial) begin
          rem_q[j]  <= rem_in - trial[RW-1:0];
          root_q[j] <= root_in | (QW'(1) << Bit);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[QW-1];

endmodule

### design/tsg_div.sv
// pipelined restoring divider for q1.16 ratios, one quotient bit per stage
module tsg_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [tsg_pkg::DivNumW-1:0]     num_i,
  input  logic [tsg_pkg::RootW-1:0]       den_i,
  output tsg_pkg::quo_t                   quo_o
);

  localparam int unsigned QW = tsg_pkg::QuoW;
  localparam int unsigned DW = tsg_pkg::RootW;
  localparam int unsigned NW = tsg_pkg::DivNumW;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stg
    localparam int unsigned Bit = QW - 1 - j;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          fits;

    if (j == 0) begin : g_first
      assign rem_in = num_i[NW-1:QW];
      assign low_in = num_i[QW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // bring down the next dividend bit and compare
    assign trial = {rem_in, low_in[Bit]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= fits ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        low_q[j] <= low_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (QW'(fits) << Bit);
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

### design/triangle_setup_geometry_unit.sv
// triangle setup: centroid, unit normal, squared radius and normal angle terms
//
// input stream: one triangle per beat on s_axis, nine signed q16.16 coordinates.
// output stream: one result beat on m_axis per triangle, in the same order.
// config channel: cfg_valid_i/cfg_data_i write the normal length floor; it is
// always ready. the user must write it only while no triangle is in flight;
// the block itself does not enforce this. the pipe runs through the two 32
// stage square root pipes and the 17 stage divider pipes behind them.
// rate: one triangle per cycle unless stalled; every stage holds a valid bit.
// reset: all valid bits clear, the floor returns to 1, s_axis_tready is high.
// stall: when the output beat waits on m_axis_tready the whole pipe holds and
// s_axis_tready drops; nothing is lost or repeated, and bubbles in the pipe
// keep moving while the output stage is empty.
module triangle_setup_geometry_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // vertex0_x, y, z, vertex1_x, y, z, vertex2_x, y, z, 32 bits each
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tsg_pkg::InTdataW-1:0]    s_axis_tdata,
  // center_x, y, z (32), normal_x, y, z (18), radius_squared (48),
  // longitude sine and cosine, latitude sine and cosine (18), 2 pad bits
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tsg_pkg::OutTdataW-1:0]   m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [15:0]                     cfg_data_i
);

  localparam int unsigned CW       = tsg_pkg::CoordW;
  localparam int unsigned RtW      = tsg_pkg::RootW;
  localparam int unsigned QW       = tsg_pkg::QuoW;
  localparam int unsigned NW       = tsg_pkg::DivNumW;
  localparam int unsigned FW       = tsg_pkg::FracW;
  localparam int unsigned CenStg   = 4;
  localparam int unsigned RadStg   = 10;
  localparam int unsigned DivInStg = 44;
  localparam int unsigned OutStg   = DivInStg + QW + 1;
  localparam int unsigned CenDly   = OutStg - 1 - CenStg;
  localparam int unsigned RadDly   = OutStg - 1 - RadStg;
  localparam int unsigned SdDly    = 6;
  localparam int EdgeP [3] = '{0, 0, 1};
  localparam int EdgeQ [3] = '{1, 2, 2};
  localparam int EdgeO [3] = '{2, 1, 0};

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][30:0]  mag;
    logic [31:0]       flr;
  } geo_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       dz;
    logic       hz;
    logic       lz;
  } flg_t;

  function automatic logic [FW-1:0] enc_q(input logic neg, input tsg_pkg::quo_t m);
    enc_q = neg ? FW'(-{1'b0, m}) : {1'b0, m};
  endfunction

  logic              en;
  logic [OutStg-1:0] vld_q;
  logic [15:0]       mnl_q;

  // pipe advances unless a finished beat is blocked
  assign en            = !vld_q[OutStg-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[OutStg-1];
  assign cfg_ready_o   = 1'b1;

  // valid bits and floor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      mnl_q <= tsg_pkg::MinLenReset;
    end else begin
      if (en) begin
        vld_q <= {vld_q[OutStg-2:0], s_axis_tvalid};
      end
      if (cfg_valid_i) begin
        mnl_q <= cfg_data_i;
      end
    end
  end

  // stage signals
  logic signed [CW-1:0] vtx_q [9];
  logic [34:0]          cu_d [3], cu_q [3];
  logic signed [32:0]   dif_d [6], dif_q [6];
  logic signed [34:0]   ew_d [9], ew_q [9];
  logic [50:0]          cpl_d [3], cpl_q [3];
  logic [51:0]          cph_d [3], cph_q [3];
  logic [32:0]          dm_d [6], dm_q [6];
  logic [5:0]           dneg_d, dneg_q;
  logic [1:0]           sd_d;
  logic [1:0]           sd_q [SdDly];
  logic [33:0]          ewm_d [9], ewm_q [9];
  logic [68:0]          ctot [3];
  logic [2:0][31:0]     cen_d, cen_q;
  logic [32:0]          dms [6];
  logic signed [31:0]   d_d [6], d_q [6];
  logic [33:0]          rhh_d [9], rhh_q [9];
  logic [33:0]          rhl_d [9], rhl_q [9];
  logic [33:0]          rll_d [9], rll_q [9];
  logic signed [63:0]   prd_d [6], prd_q [6];
  logic [67:0]          msq_d [9], msq_q [9];
  logic signed [63:0]   cr_d [3], cr_q [3];
  logic [67:0]          rsum [3];
  logic [51:0]          rwh_d [3], rwh_q [3];
  logic [62:0]          cm_d [3], cm7_q [3], cm8_q [3];
  logic [2:0]           cn_d, cn7_q, cn8_q, cn9_q, cn10_q;
  logic [51:0]          rmin_d, rmin_q;
  logic [62:0]          orv;
  logic [5:0]           k_d, k_q;
  logic [50:0]          ru_d, ru_q;
  logic [30:0]          cs_d [3], cs9_q [3], cs10_q [3];
  logic [5:0]           shamt;
  logic [31:0]          flr_d, flr9_q, flr10_q;
  logic [68:0]          rp_d [3], rp_q [3];
  logic [61:0]          sq_d [3], sq_q [3];
  logic [102:0]         rtot;
  logic [47:0]          rad_d, rad_q;
  logic [63:0]          sxz_d, sxz_q, sal_d, sal_q;
  geo_t                 geo_d, geo_q;
  geo_t                 geo_dly_q [RtW];
  logic [RtW-1:0]       hxz, len;
  geo_t                 geo_w;
  logic [31:0]          den_max;
  logic [31:0]          nm [7], dv [7];
  logic [NW-1:0]        dn_d [7], dn_q [7];
  logic [31:0]          dd_q [7];
  flg_t                 flg_d, flg_q;
  flg_t                 flg_dly_q [QW];
  logic [2:0][31:0]     cen_dly_q [CenDly];
  logic [47:0]          rad_dly_q [RadDly];
  tsg_pkg::quo_t        quo [7];
  flg_t                 fo;
  logic [tsg_pkg::OutTdataW-1:0] out_d, out_q;

  // stage 2: centroid bias, edge differences, doubled midpoint offsets
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cu_d[l] = 35'(36'(vtx_q[l]) + 36'(vtx_q[3+l]) + 36'(vtx_q[6+l]) + 36'sd1
                    + 36'sd12884901888);
      dif_d[l]   = 33'(vtx_q[3+l]) - 33'(vtx_q[l]);
      dif_d[3+l] = 33'(vtx_q[6+l]) - 33'(vtx_q[l]);
    end
    for (int e = 0; e < 3; e++) begin
      for (int l = 0; l < 3; l++) begin
        ew_d[e*3+l] = 35'(vtx_q[EdgeP[e]*3+l]) + 35'(vtx_q[EdgeQ[e]*3+l])
                      - 35'(vtx_q[EdgeO[e]*3+l]) - 35'(vtx_q[EdgeO[e]*3+l]);
      end
    end
  end

  // stage 3: reciprocal partial products, magnitudes, pre-shift count
  always_comb begin
    logic big, mid;
    big = 1'b0;
    mid = 1'b0;
    for (int l = 0; l < 3; l++) begin
      cpl_d[l] = 51'(cu_q[l][16:0]) * 51'(tsg_pkg::RecipThree);
      cph_d[l] = 52'(cu_q[l][34:17]) * 52'(tsg_pkg::RecipThree);
    end
    for (int i = 0; i < 6; i++) begin
      dneg_d[i] = dif_q[i][32];
      dm_d[i]   = dif_q[i][32] ? 33'(-dif_q[i]) : 33'(dif_q[i]);
      if (dif_q[i] == {1'b1, 32'd0}) begin
        big = 1'b1;
      end
      if (dif_q[i][32] ? (!dif_q[i][31] || dif_q[i][30:0] == '0) : dif_q[i][31]) begin
        mid = 1'b1;
      end
    end
    sd_d = big ? 2'd2 : (mid ? 2'd1 : 2'd0);
    for (int i = 0; i < 9; i++) begin
      ewm_d[i] = ew_q[i][34] ? 34'(-ew_q[i]) : 34'(ew_q[i]);
    end
  end

  // stage 4: centroid, scaled edge vectors, split squares
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ctot[l]  = (69'(cph_q[l]) << 17) + 69'(cpl_q[l]);
      cen_d[l] = ctot[l][66:35];
    end
    for (int i = 0; i < 6; i++) begin
      dms[i] = dm_q[i] >> sd_q[0];
      d_d[i] = dneg_q[i] ? 32'(-{1'b0, dms[i][30:0]}) : {1'b0, dms[i][30:0]};
    end
    for (int i = 0; i < 9; i++) begin
      rhh_d[i] = 34'(ewm_q[i][33:17]) * 34'(ewm_q[i][33:17]);
      rhl_d[i] = 34'(ewm_q[i][33:17]) * 34'(ewm_q[i][16:0]);
      rll_d[i] = 34'(ewm_q[i][16:0]) * 34'(ewm_q[i][16:0]);
    end
  end

  // stage 5: cross product terms, squared offsets per axis
  always_comb begin
    prd_d[0] = 64'(d_q[4]) * 64'(d_q[2]);
    prd_d[1] = 64'(d_q[5]) * 64'(d_q[1]);
    prd_d[2] = 64'(d_q[5]) * 64'(d_q[0]);
    prd_d[3] = 64'(d_q[3]) * 64'(d_q[2]);
    prd_d[4] = 64'(d_q[3]) * 64'(d_q[1]);
    prd_d[5] = 64'(d_q[4]) * 64'(d_q[0]);
    for (int i = 0; i < 9; i++) begin
      msq_d[i] = {rhh_q[i], rll_q[i]} + (68'(rhl_q[i]) << 18);
    end
  end

  // stage 6: cross product, squared distance per edge
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_d[i]  = prd_q[2*i] - prd_q[2*i+1];
      rsum[i]  = msq_q[i*3] + msq_q[i*3+1] + msq_q[i*3+2];
      rwh_d[i] = rsum[i][67:16];
    end
  end

  // stage 7: cross magnitudes, smallest edge distance
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cn_d[i] = cr_q[i][63];
      cm_d[i] = cr_q[i][63] ? 63'(-cr_q[i]) : 63'(cr_q[i]);
    end
    rmin_d = rwh_q[0];
    if (rwh_q[1] < rmin_d) begin
      rmin_d = rwh_q[1];
    end
    if (rwh_q[2] < rmin_d) begin
      rmin_d = rwh_q[2];
    end
  end

  // stage 8: normalizing shift, rounding bias for the divide by 36
  always_comb begin
    orv = cm7_q[0] | cm7_q[1] | cm7_q[2];
    k_d = '0;
    for (int i = 31; i < 63; i++) begin
      if (orv[i]) begin
        k_d = 6'(i - 30);
      end
    end
    ru_d = 51'((53'(rmin_q) + 53'd18) >> 2);
  end

  // stage 9: shifted components, floor in the same units, reciprocal terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs_d[i] = 31'(cm8_q[i] >> k_q);
      rp_d[i] = 69'(ru_q[17*i +: 17]) * 69'(tsg_pkg::RecipNine);
    end
    shamt = k_q + {3'd0, sd_q[SdDly-1], 1'b0};
    flr_d = {mnl_q, 16'd0} >> shamt;
  end

  // stage 10: squares of components, squared radius
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = 62'(cs9_q[i]) * 62'(cs9_q[i]);
    end
    rtot  = 103'(rp_q[0]) + (103'(rp_q[1]) << 17) + (103'(rp_q[2]) << 34);
    rad_d = rtot[102:55];
  end

  // stage 11: radicands for both roots
  always_comb begin
    sxz_d = 64'(sq_q[0]) + 64'(sq_q[2]);
    sal_d = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    geo_d.neg = cn10_q;
    for (int i = 0; i < 3; i++) begin
      geo_d.mag[i] = cs10_q[i];
    end
    geo_d.flr = flr10_q;
  end

  tsg_isqrt u_sqrt_xz (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sxz_q),
    .root_o (hxz)
  );

  tsg_isqrt u_sqrt_all (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sal_q),
    .root_o (len)
  );

  // stage 44: divisors and rounded dividends
  always_comb begin
    geo_w   = geo_dly_q[RtW-1];
    den_max = (len > geo_w.flr) ? len : geo_w.flr;
    for (int i = 0; i < 3; i++) begin
      nm[i] = {1'b0, geo_w.mag[i]};
      dv[i] = den_max;
    end
    nm[3] = {1'b0, geo_w.mag[0]};
    dv[3] = hxz;
    nm[4] = {1'b0, geo_w.mag[2]};
    dv[4] = hxz;
    nm[5] = {1'b0, geo_w.mag[1]};
    dv[5] = len;
    nm[6] = hxz;
    dv[6] = len;
    for (int i = 0; i < 7; i++) begin
      dn_d[i] = (NW'(nm[i]) << 16) + NW'(dv[i] >> 1);
    end
    flg_d.neg = geo_w.neg;
    flg_d.dz  = den_max == '0;
    flg_d.hz  = hxz == '0;
    flg_d.lz  = len == '0;
  end

  for (genvar j = 0; j < 7; j++) begin : g_div
    tsg_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dn_q[j]),
      .den_i (dd_q[j]),
      .quo_o (quo[j])
    );
  end

  // output stage: signs and degenerate cases
  always_comb begin
    logic [FW-1:0] nx, ny, nz, slo, clo, sla, cla;
    fo  = flg_dly_q[QW-1];
    nx  = fo.dz ? '0 : enc_q(fo.neg[0], quo[0]);
    ny  = fo.dz ? '0 : enc_q(fo.neg[1], quo[1]);
    nz  = fo.dz ? '0 : enc_q(fo.neg[2], quo[2]);
    slo = fo.hz ? '0 : enc_q(fo.neg[0], quo[3]);
    clo = fo.hz ? tsg_pkg::QOne : enc_q(fo.neg[2], quo[4]);
    sla = fo.lz ? '0 : enc_q(fo.neg[1], quo[5]);
    cla = fo.lz ? tsg_pkg::QOne : {1'b0, quo[6]};
    out_d = {2'b00, cla, sla, clo, slo, rad_dly_q[RadDly-1], nz, ny, nx,
             cen_dly_q[CenDly-1][2], cen_dly_q[CenDly-1][1], cen_dly_q[CenDly-1][0]};
  end

  // payload registers of all stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        vtx_q[i] <= s_axis_tdata[i*CW +: CW];
      end
      cu_q   <= cu_d;
      dif_q  <= dif_d;
      ew_q   <= ew_d;
      cpl_q  <= cpl_d;
      cph_q  <= cph_d;
      dm_q   <= dm_d;
      dneg_q <= dneg_d;
      ewm_q  <= ewm_d;
      sd_q[0] <= sd_d;
      for (int i = 1; i < SdDly; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
      cen_q  <= cen_d;
      d_q    <= d_d;
      rhh_q  <= rhh_d;
      rhl_q  <= rhl_d;
      rll_q  <= rll_d;
      prd_q  <= prd_d;
      msq_q  <= msq_d;
      cr_q   <= cr_d;
      rwh_q  <= rwh_d;
      cm7_q  <= cm_d;
      cn7_q  <= cn_d;
      rmin_q <= rmin_d;
      cm8_q  <= cm7_q;
      cn8_q  <= cn7_q;
      k_q    <= k_d;
      ru_q   <= ru_d;
      cs9_q  <= cs_d;
      cn9_q  <= cn8_q;
      flr9_q <= flr_d;
      rp_q   <= rp_d;
      sq_q    <= sq_d;
      cs10_q  <= cs9_q;
      cn10_q  <= cn9_q;
      flr10_q <= flr9_q;
      rad_q   <= rad_d;
      sxz_q  <= sxz_d;
      sal_q  <= sal_d;
      geo_q  <= geo_d;
      geo_dly_q[0] <= geo_q;
      for (int i = 1; i < RtW; i++) begin
        geo_dly_q[i] <= geo_dly_q[i-1];
      end
      dn_q  <= dn_d;
      dd_q  <= dv;
      flg_q <= flg_d;
      flg_dly_q[0] <= flg_q;
      for (int i = 1; i < QW; i++) begin
        flg_dly_q[i] <= flg_dly_q[i-1];
      end
      cen_dly_q[0] <= cen_q;
      for (int i = 1; i < CenDly; i++) begin
        cen_dly_q[i] <= cen_dly_q[i-1];
      end
      rad_dly_q[0] <= rad_q;
      for (int i = 1; i < RadDly; i++) begin
        rad_dly_q[i] <= rad_dly_q[i-1];
      end
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

endmodule

### design/tsg_checker.sv
// port level checks for the triangle setup unit, bound to the top level
module tsg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tsg_pkg::OutTdataW-1:0]   m_axis_tdata
);

  // a blocked output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // input side stalls only behind a blocked output beat
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // cosine of latitude is never negative and never above one
  a_cos_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[269] && (m_axis_tdata[268:252] <= 17'd65536))
    else $error("cos latitude out of range");

  // normal x stays within unit magnitude
  a_norm_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[113:96]) >= -18'sd65536)
                   && ($signed(m_axis_tdata[113:96]) <= 18'sd65536))
    else $error("normal x out of range");

endmodule

bind triangle_setup_geometry_unit tsg_checker u_tsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_top.sv
// self-checking testbench for the triangle setup geometry unit
module tb_top;

  localparam int unsigned LatencyWait = 80;
  localparam int unsigned CycleLimit  = 600000;
  localparam longint unsigned Lim31   = 64'h8000_0000;

  // result fields, packed so that the last field lands in the lowest bits
  typedef struct packed {
    logic [1:0]                 pad;
    logic [tsg_pkg::FracW-1:0]  cos_lat;
    logic [tsg_pkg::FracW-1:0]  sin_lat;
    logic [tsg_pkg::FracW-1:0]  cos_lon;
    logic [tsg_pkg::FracW-1:0]  sin_lon;
    logic [tsg_pkg::R2W-1:0]    radius_sq;
    logic [tsg_pkg::FracW-1:0]  normal_z;
    logic [tsg_pkg::FracW-1:0]  normal_y;
    logic [tsg_pkg::FracW-1:0]  normal_x;
    logic [tsg_pkg::CoordW-1:0] center_z;
    logic [tsg_pkg::CoordW-1:0] center_y;
    logic [tsg_pkg::CoordW-1:0] center_x;
  } setup_beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [tsg_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [tsg_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [15:0]                   cfg_data_i = '0;

  logic [tsg_pkg::InTdataW-1:0] pending_tris[$];
  setup_beat_t         expected_setups[$];
  logic [15:0]         floor_shadow = tsg_pkg::MinLenReset;
  int unsigned         send_gap = 0;
  bit                  no_gaps = 1'b0;
  bit                  hold_req = 1'b0;
  int unsigned         hold_left = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycles = 0;

  triangle_setup_geometry_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // q1.16 ratio, rounded half away from zero
  function automatic logic [tsg_pkg::FracW-1:0] q16_quot(bit neg, longint unsigned num,
                                                         longint unsigned den);
    longint unsigned m;
    m = (num * 65536 + den / 2) / den;
    return neg ? tsg_pkg::FracW'(-m) : tsg_pkg::FracW'(m);
  endfunction

  function automatic longint unsigned abs64(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  // squared distance centroid to midpoint of edge p-q, o the far vertex
  function automatic longint unsigned midpoint_dist_sq(longint p[3], longint q[3],
                                                       longint o[3]);
    longint unsigned whole, frac, m, hi, lo, r;
    whole = 0;
    frac = 0;
    for (int l = 0; l < 3; l++) begin
      m = abs64(p[l] + q[l] - 2 * o[l]);
      hi = m >> 17;
      lo = m & 64'h1FFFF;
      whole += ((hi * hi) << 18) + hi * lo * 4 + ((lo * lo) >> 16);
      frac += (lo * lo) & 64'hFFFF;
    end
    whole += frac >> 16;
    r = (whole + 18) / 36;
    return r > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : r;
  endfunction

  // full prediction of one result beat from one triangle
  function automatic setup_beat_t predict_setup(logic [tsg_pkg::InTdataW-1:0] t);
    setup_beat_t      res;
    longint           v0[3], v1[3], v2[3], d[6], cr[3], s, q, r;
    longint unsigned  dm[6], cm[3], len, hxz, flr, den, r2, rr;
    bit               dn[6], cn[3];
    int unsigned      sd, k;
    res = '0;
    for (int l = 0; l < 3; l++) begin
      v0[l] = longint'($signed(t[l*32 +: 32]));
      v1[l] = longint'($signed(t[(3+l)*32 +: 32]));
      v2[l] = longint'($signed(t[(6+l)*32 +: 32]));
    end
    // centroid, nearest integer
    for (int l = 0; l < 3; l++) begin
      s = v0[l] + v1[l] + v2[l];
      q = s / 3;
      r = s % 3;
      if (r < 0) begin
        q--;
        r += 3;
      end
      if (r == 2) q++;
      case (l)
        0: res.center_x = q[31:0];
        1: res.center_y = q[31:0];
        default: res.center_z = q[31:0];
      endcase
    end
    // edge differences with common scaling
    for (int l = 0; l < 3; l++) begin
      dn[l] = (v1[l] - v0[l]) < 0;
      dm[l] = abs64(v1[l] - v0[l]);
      dn[3+l] = (v2[l] - v0[l]) < 0;
      dm[3+l] = abs64(v2[l] - v0[l]);
    end
    sd = 0;
    for (int i = 0; i < 6; i++) while ((dm[i] >> sd) >= Lim31) sd++;
    for (int i = 0; i < 6; i++) d[i] = dn[i] ? -longint'(dm[i] >> sd) : longint'(dm[i] >> sd);
    cr[0] = d[4] * d[2] - d[5] * d[1];
    cr[1] = d[5] * d[0] - d[3] * d[2];
    cr[2] = d[3] * d[1] - d[4] * d[0];
    k = 0;
    for (int i = 0; i < 3; i++) begin
      cn[i] = cr[i] < 0;
      cm[i] = abs64(cr[i]);
    end
    for (int i = 0; i < 3; i++) while ((cm[i] >> k) >= Lim31) k++;
    for (int i = 0; i < 3; i++) cm[i] >>= k;
    hxz = int_sqrt(cm[0] * cm[0] + cm[2] * cm[2]);
    len = int_sqrt(cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2]);
    flr = (longint'(floor_shadow) << 16) >> (k + 2 * sd);
    den = len > flr ? len : flr;
    // normal, zero when the divisor vanishes
    if (den != 0) begin
      res.normal_x = q16_quot(cn[0], cm[0], den);
      res.normal_y = q16_quot(cn[1], cm[1], den);
      res.normal_z = q16_quot(cn[2], cm[2], den);
    end
    // true minimum over every edge of the triangle
    r2 = midpoint_dist_sq(v0, v1, v2);
    rr = midpoint_dist_sq(v0, v2, v1);
    if (rr < r2) r2 = rr;
    rr = midpoint_dist_sq(v1, v2, v0);
    if (rr < r2) r2 = rr;
    res.radius_sq = r2[tsg_pkg::R2W-1:0];
    // angle terms with their zero-denominator fallbacks
    if (hxz == 0) begin
      res.cos_lon = tsg_pkg::QOne;
    end else begin
      res.sin_lon = q16_quot(cn[0], cm[0], hxz);
      res.cos_lon = q16_quot(cn[2], cm[2], hxz);
    end
    if (len == 0) begin
      res.cos_lat = tsg_pkg::QOne;
    end else begin
      res.sin_lat = q16_quot(cn[1], cm[1], len);
      res.cos_lat = q16_quot(1'b0, hxz, len);
    end
    return res;
  endfunction

  function automatic logic [tsg_pkg::InTdataW-1:0] pack_tri(int c[9]);
    logic [tsg_pkg::InTdataW-1:0] t;
    t = '0;
    for (int i = 0; i < 9; i++) t[i*32 +: 32] = c[i];
    return t;
  endfunction

  // random triangle: coordinates mostly near a base at a random scale, some full range
  function automatic logic [tsg_pkg::InTdataW-1:0] random_tri();
    int c[9];
    int base[3];
    int sh, osh;
    sh = $urandom_range(0, 31);
    osh = $urandom_range(0, 31);
    for (int l = 0; l < 3; l++) base[l] = $signed($urandom) >>> sh;
    for (int i = 0; i < 9; i++) begin
      if ($urandom_range(0, 9) < 2) c[i] = $urandom;
      else c[i] = base[i % 3] + ($signed($urandom) >>> osh);
    end
    return pack_tri(c);
  endfunction

  // sender: one item per beat, random gaps between beats unless no_gaps is set
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid) expected_setups.push_back(predict_setup(s_axis_tdata));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_tris.pop_front();
        if (no_gaps) send_gap <= 0;
        else if ($urandom_range(0, 9) < 6) send_gap <= 0;
        else if ($urandom_range(0, 9) < 8) send_gap <= $urandom_range(1, 3);
        else send_gap <= $urandom_range(10, 40);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with random stalls unless no_gaps is set, and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_left <= 400;
        m_axis_tready <= 1'b0;
      end else if (no_gaps) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 :
                         ($urandom_range(0, 9) < 9) ? 1'b0 : ($urandom_range(0, 30) == 0);
      end
    end
  end

  function automatic void check_field(string name, logic [tsg_pkg::R2W-1:0] exp_v,
                                      logic [tsg_pkg::R2W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    setup_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_setups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = expected_setups.pop_front();
        check_field("center_x", want.center_x, got.center_x);
        check_field("center_y", want.center_y, got.center_y);
        check_field("center_z", want.center_z, got.center_z);
        check_field("normal_x", want.normal_x, got.normal_x);
        check_field("normal_y", want.normal_y, got.normal_y);
        check_field("normal_z", want.normal_z, got.normal_z);
        check_field("radius_squared", want.radius_sq, got.radius_sq);
        check_field("sin_lon", want.sin_lon, got.sin_lon);
        check_field("cos_lon", want.cos_lon, got.cos_lon);
        check_field("sin_lat", want.sin_lat, got.sin_lat);
        check_field("cos_lat", want.cos_lat, got.cos_lat);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_tris.size() > 0 || s_axis_tvalid || expected_setups.size() > 0);
    repeat (LatencyWait) @(posedge clk_i);
  endtask

  task automatic write_floor(logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    floor_shadow = val;
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) pending_tris.push_back(random_tri());
  endtask

  // directed corners
  task automatic add_directed();
    int mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    pending_tris.push_back(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    pending_tris.push_back(pack_tri('{mx, mx, mx, mx, mx, mx, mx, mx, mx}));
    pending_tris.push_back(pack_tri('{mn, mn, mn, mn, mn, mn, mn, mn, mn}));
    // widest edges, forces difference scaling
    pending_tris.push_back(pack_tri('{mn, mn, mn, mx, mn, mx, mn, mx, mx}));
    pending_tris.push_back(pack_tri('{mx, mn, mx, mn, mx, mn, mx, mx, mn}));
    pending_tris.push_back(pack_tri('{-1, -1, -1, 1, 0, -1, 0, 1, 0}));
    // collinear points, degenerate normal
    pending_tris.push_back(pack_tri('{0, 0, 0, 65536, 65536, 65536, 131072, 131072, 131072}));
    // triangle in the xz plane, normal along y: zero longitude denominator
    pending_tris.push_back(pack_tri('{0, 5, 0, 65536, 5, 0, 0, 5, 65536}));
    // xy plane and yz plane
    pending_tris.push_back(pack_tri('{0, 0, 7, 65536, 0, 7, 0, 65536, 7}));
    pending_tris.push_back(pack_tri('{3, 0, 0, 3, 65536, 0, 3, 0, -65536}));
    // isosceles, tied midpoint distances
    pending_tris.push_back(pack_tri('{0, 0, 0, 65536, 0, 0, 32768, 56756, 0}));
    pending_tris.push_back(pack_tri('{-65536, 0, 0, 65536, 0, 0, 0, 65536, 0}));
    // tiny triangle, floor dominates
    pending_tris.push_back(pack_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    pending_tris.push_back(pack_tri('{100, 200, 300, 101, 199, 302, 98, 203, 299}));
    // huge radius
    pending_tris.push_back(pack_tri('{mn, mn, mn, mx, mx, mx, mn, mx, mn}));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset floor
    add_directed();
    add_random(170);
    wait_drained();
    // zero floor
    write_floor(16'd0);
    add_directed();
    add_random(130);
    wait_drained();
    // largest floor, full rate with a long output stall
    write_floor(16'hFFFF);
    no_gaps = 1'b1;
    hold_req = 1'b1;
    add_directed();
    add_random(130);
    wait_drained();
    no_gaps = 1'b0;
    // random floor
    write_floor(16'($urandom));
    add_random(130);
    wait_drained();
    write_floor(16'd1);
    add_random(130);
    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
